>>> rtl/core/tod_pkg.sv
// shared types, codes and sizing for the time-of-day plan table
`timescale 1ns / 1ps

package tod_pkg;

  // default number of table entries
  localparam int TOD_TABLE_ENTRIES = 32;

  // operation codes
  localparam logic [1:0] OP_UPSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // request payload
  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] schedule_number;
    logic [7:0]  segment_number;
    logic [15:0] action_number;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [4:0]  current_hour;
    logic [5:0]  current_minute;
  } tod_req_t;

  // response payload
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_action;
  } tod_rsp_t;

  // one stored table entry
  typedef struct packed {
    logic [15:0] schedule;
    logic [7:0]  segment;
    logic [15:0] action;
    logic [10:0] start_minutes;
  } tod_entry_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic shift;
    logic shift_end;
    logic out_load;
  } tod_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic       scan_done;
    logic       shift_done;
    logic       match;
    logic [1:0] op;
  } tod_stat_t;

endpackage

>>> rtl/core/tod_stream_if.sv
// valid/ready channel carrying one payload per request
`timescale 1ns / 1ps

interface tod_stream_if #(
  parameter type payload_t = logic [0:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/tod_ctrl.sv
// controller state machine sequencing scan, decision, shift and response
`timescale 1ns / 1ps

module tod_ctrl
  import tod_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  tod_stat_t stat,
  output tod_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.scan      = (state == S_SCAN);
    cmd.decide    = (state == S_DECIDE);
    cmd.shift     = (state == S_SHIFT);
    cmd.shift_end = (state == S_SHIFT) && stat.shift_done;
    cmd.out_load  = (state == S_DONE) && out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.op == OP_DELETE && stat.match) state_next = S_SHIFT;
        else state_next = S_DONE;
      end
      S_SHIFT: begin
        if (stat.shift_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/core/tod_dp.sv
// datapath: entry memory, scan pointer, match and lookup accumulators
`timescale 1ns / 1ps

module tod_dp
  import tod_pkg::*;
#(
  parameter int TABLE_ENTRIES = TOD_TABLE_ENTRIES
) (
  input  logic      clk,
  input  logic      rst,
  input  tod_req_t  req_payload,
  input  tod_cmd_t  cmd,
  output tod_stat_t stat,
  output tod_rsp_t  rsp_payload
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);
  localparam logic [10:0] MINUTES_PER_HOUR = 11'd60;

  // entry storage
  tod_entry_t mem [TABLE_ENTRIES];
  tod_entry_t rd_data;

  // control registers
  logic [CW-1:0] entry_count;
  logic          rd_vld;

  // request and scan registers
  logic [CW-1:0] ptr;
  logic [AW-1:0] rd_idx;
  logic [1:0]    op;
  logic [15:0]   key_sched;
  logic [7:0]    key_seg;
  logic [15:0]   new_act;
  logic [10:0]   new_start;
  logic [10:0]   now_min;
  logic          match;
  logic [AW-1:0] match_idx;
  logic          any;
  logic          earlier;
  logic [10:0]   latest;
  logic [15:0]   latest_act;
  logic [10:0]   best_diff;
  logic [15:0]   earlier_act;
  logic [1:0]    res_status;
  logic [15:0]   res_action;

  // combinational helpers
  logic          full;
  logic [CW-1:0] ptr_inc;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  tod_entry_t    wr_data;
  logic          sched_hit;
  logic          key_hit;
  logic [10:0]   diff;

  function automatic logic [10:0] to_minutes(input logic [4:0] hour, input logic [5:0] minute);
    to_minutes = 11'(hour) * MINUTES_PER_HOUR + 11'(minute);
  endfunction

  assign full    = (entry_count == FULL_COUNT);
  assign ptr_inc = ptr + CW'(1);

  // read port: scan walks ptr, shift reads one ahead of the slot being filled
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr[AW-1:0];
    if (cmd.scan) begin
      rd_en   = (ptr < entry_count);
      rd_addr = ptr[AW-1:0];
    end else if (cmd.shift) begin
      rd_en   = (ptr_inc < entry_count);
      rd_addr = ptr_inc[AW-1:0];
    end
  end

  // write port: upsert commit or shifted entry
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = rd_data;
    if (cmd.decide && op == OP_UPSERT) begin
      wr_en   = match || !full;
      wr_addr = match ? match_idx : entry_count[AW-1:0];
      wr_data = '{schedule: key_sched, segment: key_seg, action: new_act,
                  start_minutes: new_start};
    end else if (cmd.shift && rd_vld) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx;
      wr_data = rd_data;
    end
  end

  // memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // compare of the entry just read
  assign sched_hit = (rd_data.schedule == key_sched);
  assign key_hit   = sched_hit && (rd_data.segment == key_seg);
  assign diff      = now_min - rd_data.start_minutes;

  // count and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      rd_vld      <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (cmd.decide && op == OP_UPSERT && !match && !full) begin
        entry_count <= entry_count + CW'(1);
      end else if (cmd.shift_end) begin
        entry_count <= entry_count - CW'(1);
      end
    end
  end

  // request latch, scan accumulators and result
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ptr    <= (cmd.shift) ? ptr_inc : ptr + CW'(1);
      rd_idx <= (cmd.shift) ? ptr[AW-1:0] : ptr[AW-1:0];
    end
    if (cmd.load) begin
      op        <= req_payload.operation;
      key_sched <= req_payload.schedule_number;
      key_seg   <= req_payload.segment_number;
      new_act   <= req_payload.action_number;
      new_start <= to_minutes(req_payload.start_hour, req_payload.start_minute);
      now_min   <= to_minutes(req_payload.current_hour, req_payload.current_minute);
      ptr       <= '0;
      match     <= 1'b0;
      any       <= 1'b0;
      earlier   <= 1'b0;
    end
    // fold one entry into find and lookup
    if (cmd.scan && rd_vld) begin
      if (key_hit && !match) begin
        match     <= 1'b1;
        match_idx <= rd_idx;
      end
      if (sched_hit) begin
        any <= 1'b1;
        if (!any || rd_data.start_minutes >= latest) begin
          latest     <= rd_data.start_minutes;
          latest_act <= rd_data.action;
        end
        if (now_min > rd_data.start_minutes && (!earlier || diff < best_diff)) begin
          earlier     <= 1'b1;
          best_diff   <= diff;
          earlier_act <= rd_data.action;
        end
      end
    end
    // settle the result; a delete hit starts the shift at the matched slot
    if (cmd.decide) begin
      unique case (op)
        OP_UPSERT: begin
          res_status <= (!match && full) ? ST_FULL : ST_OK;
          res_action <= '0;
        end
        OP_DELETE: begin
          res_status <= match ? ST_OK : ST_NOT_FOUND;
          res_action <= '0;
          if (match) ptr <= CW'(match_idx);
        end
        OP_LOOKUP: begin
          res_status <= ST_OK;
          res_action <= any ? (earlier ? earlier_act : latest_act) : '0;
        end
        default: begin
          res_status <= ST_OK;
          res_action <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      rsp_payload.status       <= res_status;
      rsp_payload.found_action <= res_action;
    end
  end

  // status to the controller
  assign stat.scan_done  = (ptr == entry_count) && !rd_vld;
  assign stat.shift_done = !(ptr_inc < entry_count) && !rd_vld;
  assign stat.match      = match;
  assign stat.op         = op;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL_COUNT)
    else $error("entry count beyond table size");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.decide && op == OP_UPSERT && !match && !full
      |=> entry_count == $past(entry_count) + CW'(1))
    else $error("append did not grow the table");

  a_shift_in_table: assert property (@(posedge clk) disable iff (rst)
    cmd.shift && rd_vld |-> (CW'(rd_idx) + CW'(1)) < entry_count)
    else $error("shift moved an entry from beyond the table");

  a_decide_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> !rd_vld)
    else $error("decision taken with a read still in flight");

endmodule

>>> rtl/core/time_of_day_plan_table_core.sv
// top level of the time-of-day plan table
//
//  channel | dir | payload                                   | handshake
//  req     | in  | operation, schedule, segment, action, times | valid/ready
//  rsp     | out | status, found_action                      | valid/ready
//
// a request passes through these steps: it is taken, the table is scanned,
// the result is decided and rsp is loaded. a delete that hits then moves the
// entries behind it up one slot each, one at a time through the single memory
// read port; no entry moves when it hit the last entry.
// reset empties the table at once; no clearing pass is needed.
// a finished response waits in an output register, the next request is
// taken while it waits; a stalled rsp holds completion of the next one.
`timescale 1ns / 1ps

module time_of_day_plan_table_core
  import tod_pkg::*;
#(
  parameter int TABLE_ENTRIES = TOD_TABLE_ENTRIES
) (
  input logic         clk,
  input logic         rst,
  tod_stream_if.sink   req,
  tod_stream_if.source rsp
);

  tod_cmd_t  cmd;
  tod_stat_t stat;
  tod_req_t  req_payload;
  tod_rsp_t  rsp_payload;
  logic      in_ready;
  logic      out_valid;

  assign req_payload = req.payload;
  assign req.ready   = in_ready;
  assign rsp.valid   = out_valid;
  assign rsp.payload = rsp_payload;

  // sequencing
  tod_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .out_ready (rsp.ready),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table storage and arithmetic
  tod_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req_payload (req_payload),
    .cmd         (cmd),
    .stat        (stat),
    .rsp_payload (rsp_payload)
  );

endmodule
